### src/afr_pkg.sv
// shared constants for the addressed frame receiver
// no dependencies; used by the top level and its port checker
`default_nettype none

package afr_pkg;

   // default geometry
   localparam int MAX_FRAME_DEF    = 64;
   localparam int HEADER_BYTES_DEF = 12;

   // fixed field widths
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int MSG_NUM_W  = 16;
   localparam int LEN_W      = 16;
   localparam int CKS_W      = 16;
   localparam int PAY_LEN_W  = 6;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_START_WORD = 1'b0,
      CSR_DEVICE_ID  = 1'b1
   } csr_index_type;

   // header byte offsets within a frame
   localparam int OFS_MSG_LO = 4;
   localparam int OFS_MSG_HI = 5;
   localparam int OFS_DEST   = 6;
   localparam int OFS_SRC    = 7;
   localparam int OFS_LEN_LO = 8;
   localparam int OFS_LEN_HI = 9;
   localparam int OFS_CKS_LO = 10;
   localparam int OFS_CKS_HI = 11;
   localparam int START_BYTES = 4;

endpackage

`default_nettype wire

### src/addressed_frame_receiver_unit.sv
// addressed frame receiver: start word hunt, header decode, payload buffer and burst out
// depends on afr_pkg
//
//   channel | prefix | direction | word
//   --------+--------+-----------+------------------------------------------------
//   request | req_   | in        | one received byte
//   result  | rsp_   | out       | one payload byte plus frame header fields
//   config  | csr_   | in        | register write (start word, device id)
//
// one received byte is taken per cycle while no burst is pending
// a good frame is replayed from the payload memory at one word per cycle while rsp_stall is low; the
//   single read port sets that, and the request side is stalled for the burst
// reset is synchronous; the payload memory needs no clearing pass, as only
//   entries written in the current frame are ever read
// rsp_ fields hold while rsp_stall is high; req_stall is high exactly while a
//   result word is pending
`default_nettype none

module addressed_frame_receiver_unit #(
   parameter int MAX_FRAME    = afr_pkg::MAX_FRAME_DEF,
   parameter int HEADER_BYTES = afr_pkg::HEADER_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wr_en,
   input  afr_pkg::csr_index_type         csr_index,
   input  logic [afr_pkg::WORD_W-1:0]     csr_wdata,
   // received bytes
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [afr_pkg::BYTE_W-1:0]     req_rx_byte,
   // payload words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [afr_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic                           rsp_has_data,
   output logic [afr_pkg::PAY_LEN_W-1:0]  rsp_payload_length,
   output logic [afr_pkg::MSG_NUM_W-1:0]  rsp_message_number,
   output logic [afr_pkg::BYTE_W-1:0]     rsp_source_id,
   output logic                           rsp_last
);
   import afr_pkg::*;

   localparam int PCW = $clog2(MAX_FRAME + 1);   // position count, holds MAX_FRAME
   localparam int AW  = $clog2(MAX_FRAME);       // memory address
   localparam int CW  = LEN_W + 1;               // frame end compare width

   // configuration registers
   logic [WORD_W-1:0]    start_word_ff;
   logic [BYTE_W-1:0]    device_id_ff;

   // receive state
   logic [PCW-1:0]       pc_ff, pc_in;
   logic [MSG_NUM_W-1:0] msg_ff, msg_in;
   logic [BYTE_W-1:0]    dest_ff, dest_in;
   logic [BYTE_W-1:0]    src_ff, src_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [CKS_W-1:0]     cks_ff, cks_in;
   logic [CKS_W-1:0]     sum_ff, sum_in;

   // burst state
   logic                 out_valid_ff, out_valid_in;
   logic                 has_data_ff, has_data_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [PCW-1:0]       cnt_ff, cnt_in;

   // payload memory
   logic [BYTE_W-1:0]    mem_q [MAX_FRAME];
   logic [BYTE_W-1:0]    rdata_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;

   // per byte decode
   logic                 in_acc, out_acc;
   logic [BYTE_W-1:0]    b;
   logic [BYTE_W-1:0]    start_byte;
   logic                 hunt_miss;
   logic [PCW-1:0]       pc_inc;
   logic [CKS_W-1:0]     cks_now;
   logic [CKS_W-1:0]     sum_add;
   logic [CW-1:0]        frame_end;
   logic                 addr_bad;

   assign b       = req_rx_byte;
   assign in_acc  = req_valid && !req_stall;
   assign out_acc = out_valid_ff && !rsp_stall;

   // expected start byte, most significant first
   always_comb begin
      case (pc_ff[1:0])
         2'd0:    start_byte = start_word_ff[31:24];
         2'd1:    start_byte = start_word_ff[23:16];
         2'd2:    start_byte = start_word_ff[15:8];
         default: start_byte = start_word_ff[7:0];
      endcase
   end

   assign hunt_miss = (pc_ff < PCW'(START_BYTES)) && (b != start_byte);
   assign pc_inc    = pc_ff + PCW'(1);
   assign sum_add   = sum_ff + CKS_W'(b);
   // checksum high byte may be the byte arriving right now
   assign cks_now   = (pc_ff == PCW'(OFS_CKS_HI)) ? {b, cks_ff[7:0]} : cks_ff;
   assign frame_end = CW'(HEADER_BYTES) + {1'b0, len_ff};
   assign addr_bad  = (dest_ff != device_id_ff) || (src_ff == device_id_ff);

   assign wr_en   = in_acc && !hunt_miss;
   assign wr_addr = pc_ff[AW-1:0];

   always_comb begin
      pc_in        = pc_ff;
      msg_in       = msg_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      len_in       = len_ff;
      cks_in       = cks_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      has_data_in  = has_data_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;

      // burst drain
      if (out_acc) begin
         if (cnt_ff == PCW'(1)) begin
            out_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + AW'(1);
            cnt_in = cnt_ff - PCW'(1);
         end
      end

      if (in_acc) begin
         if (hunt_miss) begin
            pc_in = '0;
         end else begin
            // header capture, written straight into the header registers
            case (pc_ff)
               PCW'(OFS_MSG_LO): msg_in[7:0]   = b;
               PCW'(OFS_MSG_HI): msg_in[15:8]  = b;
               PCW'(OFS_DEST):   dest_in       = b;
               PCW'(OFS_SRC):    src_in        = b;
               PCW'(OFS_LEN_LO): len_in[7:0]   = b;
               PCW'(OFS_LEN_HI): len_in[15:8]  = b;
               PCW'(OFS_CKS_LO): cks_in[7:0]   = b;
               PCW'(OFS_CKS_HI): cks_in[15:8]  = b;
               default: ;
            endcase

            if (pc_inc == PCW'(HEADER_BYTES)) begin
               // header complete
               sum_in = '0;
               if (addr_bad) begin
                  pc_in = '0;
               end else if (len_ff == '0) begin
                  pc_in = '0;
                  if (cks_now == '0) begin
                     out_valid_in = 1'b1;
                     has_data_in  = 1'b0;
                     cnt_in       = PCW'(1);
                  end
               end else begin
                  pc_in = (pc_inc >= PCW'(MAX_FRAME)) ? '0 : pc_inc;
               end
            end else if ((pc_inc > PCW'(HEADER_BYTES)) && (CW'(pc_inc) == frame_end)) begin
               // last payload byte
               sum_in = sum_add;
               pc_in  = '0;
               if (sum_add == cks_ff) begin
                  out_valid_in = 1'b1;
                  has_data_in  = 1'b1;
                  idx_in       = AW'(HEADER_BYTES);
                  cnt_in       = len_ff[PCW-1:0];
               end
            end else begin
               sum_in = sum_add;
               pc_in  = (pc_inc >= PCW'(MAX_FRAME)) ? '0 : pc_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= '0;
         device_id_ff  <= '0;
         pc_ff         <= '0;
         msg_ff        <= '0;
         dest_ff       <= '0;
         src_ff        <= '0;
         len_ff        <= '0;
         cks_ff        <= '0;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
         has_data_ff   <= 1'b0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_WORD: start_word_ff <= csr_wdata;
               CSR_DEVICE_ID:  device_id_ff  <= csr_wdata[BYTE_W-1:0];
               default: ;
            endcase
         end
         pc_ff        <= pc_in;
         msg_ff       <= msg_in;
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         len_ff       <= len_in;
         cks_ff       <= cks_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         has_data_ff  <= has_data_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload memory: read address follows the next burst index, so rdata_ff
   // always shows the entry at idx_ff; a same-cycle write is forwarded
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= b;
      end
      if (wr_en && (wr_addr == idx_in)) begin
         rdata_ff <= b;
      end else begin
         rdata_ff <= mem_q[idx_in];
      end
   end

   assign req_stall          = out_valid_ff;
   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = has_data_ff ? rdata_ff : '0;
   assign rsp_has_data       = has_data_ff;
   assign rsp_payload_length = len_ff[PAY_LEN_W-1:0];
   assign rsp_message_number = msg_ff;
   assign rsp_source_id      = src_ff;
   assign rsp_last           = (cnt_ff == PCW'(1));

endmodule

`default_nettype wire

### src/afr_checker.sv
// port-level checks for the addressed frame receiver, bound to the top level
// depends on afr_pkg
`default_nettype none

module afr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_stall,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [afr_pkg::BYTE_W-1:0]     rsp_payload_byte,
   input  logic                           rsp_has_data,
   input  logic [afr_pkg::PAY_LEN_W-1:0]  rsp_payload_length,
   input  logic [afr_pkg::MSG_NUM_W-1:0]  rsp_message_number,
   input  logic [afr_pkg::BYTE_W-1:0]     rsp_source_id,
   input  logic                           rsp_last
);
   import afr_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_last) && $stable(rsp_has_data))
      else $error("result word changed while stalled");

   // receive side is held off while a burst is pending
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during a burst");

   // an empty frame is a single word with zero payload
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_last && (rsp_payload_byte == '0)
         && (rsp_payload_length == '0))
      else $error("bad zero-length result");

   // a burst continues without gaps and keeps its header fields
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_has_data
         && $stable(rsp_message_number) && $stable(rsp_source_id)
         && $stable(rsp_payload_length))
      else $error("burst broken");

endmodule

bind addressed_frame_receiver_unit afr_checker u_afr_checker (.*);

`default_nettype wire

### test/addressed_frame_receiver_unit_tb.sv
// self-checking testbench for addressed_frame_receiver_unit: random byte streams of
// framed, broken and noise traffic, with an in-bench frame predictor checking every word
// depends on afr_pkg and the addressed_frame_receiver_unit rtl
`default_nettype none

module addressed_frame_receiver_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afr_pkg::*;

   localparam int FRAME_BYTES   = MAX_FRAME_DEF;
   localparam int HDR_BYTES     = HEADER_BYTES_DEF;
   localparam int MAX_PAYLOAD   = FRAME_BYTES - HDR_BYTES;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;

   // one result word as the block presents it
   typedef struct packed {
      logic [BYTE_W-1:0]    payload_byte;
      logic                 has_data;
      logic [PAY_LEN_W-1:0] payload_length;
      logic [MSG_NUM_W-1:0] message_number;
      logic [BYTE_W-1:0]    source_id;
      logic                 last;
   } frame_word_type;

   // dut ports, all inputs driven from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   csr_index_type        csr_index = CSR_START_WORD;
   logic [WORD_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_has_data;
   logic [PAY_LEN_W-1:0] rsp_payload_length;
   logic [MSG_NUM_W-1:0] rsp_message_number;
   logic [BYTE_W-1:0]    rsp_source_id;
   logic                 rsp_last;

   addressed_frame_receiver_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_payload_length (rsp_payload_length),
      .rsp_message_number (rsp_message_number),
      .rsp_source_id      (rsp_source_id),
      .rsp_last           (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectation stores
   logic [BYTE_W-1:0] rx_bytes_pending[$];
   frame_word_type    expected_words[$];
   int unsigned       mismatch_count = 0;

   // idling controls, set per phase
   bit          send_gaps = 1'b0;
   bit          recv_gaps = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned hold_cycles_left = 0;
   int unsigned send_idle_left = 0;
   int unsigned recv_stall_left = 0;

   // ---------------------------------------------------------------------------------------
   // frame predictor: own copy of the configuration and the receive state
   // ---------------------------------------------------------------------------------------
   logic [WORD_W-1:0]    cfg_start_word;
   logic [BYTE_W-1:0]    cfg_device_id;
   int unsigned          rx_pos;
   logic [BYTE_W-1:0]    frame_mem[FRAME_BYTES];
   logic [MSG_NUM_W-1:0] hdr_msg_num;
   logic [BYTE_W-1:0]    hdr_src;
   logic [LEN_W-1:0]     hdr_len;
   logic [CKS_W-1:0]     hdr_cks;
   logic [CKS_W-1:0]     payload_sum;

   function automatic void predict_rx_byte(input logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] dest;
      frame_word_type    w;
      int unsigned       i;
      if (rx_pos >= FRAME_BYTES) rx_pos = 0;
      // start word hunt; a mismatch never rechecks the byte as a first start byte
      if (rx_pos < START_BYTES && rx != cfg_start_word[WORD_W-1-8*rx_pos -: 8]) begin
         rx_pos = 0;
         return;
      end
      frame_mem[rx_pos] = rx;
      rx_pos++;
      payload_sum = payload_sum + CKS_W'(rx);
      if (rx_pos == HDR_BYTES) begin
         dest        = frame_mem[OFS_DEST];
         hdr_msg_num = {frame_mem[OFS_MSG_HI], frame_mem[OFS_MSG_LO]};
         hdr_src     = frame_mem[OFS_SRC];
         hdr_len     = {frame_mem[OFS_LEN_HI], frame_mem[OFS_LEN_LO]};
         hdr_cks     = {frame_mem[OFS_CKS_HI], frame_mem[OFS_CKS_LO]};
         payload_sum = '0;
         if (dest != cfg_device_id || hdr_src == cfg_device_id) begin
            rx_pos = 0;
            return;
         end
         // empty frame finishes right here
         if (hdr_len == 0) begin
            if (hdr_cks == 0) begin
               w = '{payload_byte: '0, has_data: 1'b0, payload_length: hdr_len[PAY_LEN_W-1:0],
                     message_number: hdr_msg_num, source_id: hdr_src, last: 1'b1};
               expected_words.push_back(w);
            end
            rx_pos = 0;
         end
         return;
      end
      if (rx_pos > HDR_BYTES && rx_pos == HDR_BYTES + hdr_len) begin
         if (payload_sum == hdr_cks) begin
            for (i = 0; i < hdr_len; i++) begin
               w = '{payload_byte: frame_mem[HDR_BYTES+i], has_data: 1'b1,
                     payload_length: hdr_len[PAY_LEN_W-1:0], message_number: hdr_msg_num,
                     source_id: hdr_src, last: (i + 1 == hdr_len)};
               expected_words.push_back(w);
            end
         end
         rx_pos = 0;
      end
      if (rx_pos >= FRAME_BYTES) rx_pos = 0;
   endfunction

   // idle length: mostly none, often short, now and then long
   function automatic int unsigned pick_idle(input bit enable);
      int unsigned r;
      if (!enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------------------------
   // driver: offers queued bytes, predicts on every accepted word
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_rx_byte(req_rx_byte);
            send_idle_left = pick_idle(send_gaps);
         end
         // payload only moves when nothing is held on the port
         if (!req_valid || !req_stall) begin
            if (send_idle_left > 0) begin
               send_idle_left--;
               req_valid <= 1'b0;
            end else if (rx_bytes_pending.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_cycles_left > 0) begin
         hold_cycles_left--;
      end else if (hold_request) begin
         hold_cycles_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: checks each accepted word against the oldest expectation
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_word_type got;
      frame_word_type exp_w;
      bit             stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{payload_byte: rsp_payload_byte, has_data: rsp_has_data,
                    payload_length: rsp_payload_length, message_number: rsp_message_number,
                    source_id: rsp_source_id, last: rsp_last};
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: byte %h data %b len %0d msg %h src %h last %b",
                           got.payload_byte, got.has_data, got.payload_length,
                           got.message_number, got.source_id, got.last);
            end else begin
               exp_w = expected_words.pop_front();
               if (got.payload_byte !== exp_w.payload_byte ||
                   got.has_data !== exp_w.has_data ||
                   got.payload_length !== exp_w.payload_length ||
                   got.message_number !== exp_w.message_number ||
                   got.source_id !== exp_w.source_id ||
                   got.last !== exp_w.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"word mismatch at %0t: expected byte %h data %b len %0d msg %h",
                               " src %h last %b, got byte %h data %b len %0d msg %h src %h",
                               " last %b"}, $realtime,
                              exp_w.payload_byte, exp_w.has_data, exp_w.payload_length,
                              exp_w.message_number, exp_w.source_id, exp_w.last,
                              got.payload_byte, got.has_data, got.payload_length,
                              got.message_number, got.source_id, got.last);
               end
            end
         end
         // random back-pressure, plus the long hold when requested
         if (recv_stall_left > 0) begin
            recv_stall_left--;
            stall_next = 1'b1;
         end else begin
            recv_stall_left = pick_idle(recv_gaps);
            stall_next = (recv_stall_left > 0);
            if (stall_next) recv_stall_left--;
         end
         rsp_stall <= stall_next || (hold_cycles_left > 0);
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic write_csr(input csr_index_type idx, input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_START_WORD) cfg_start_word = value;
      else cfg_device_id = value[BYTE_W-1:0];
   endtask

   // fill: 0 random body, 1 all ones, 2 all zeros
   function automatic void push_frame(input logic [MSG_NUM_W-1:0] msg,
                                      input logic [BYTE_W-1:0] dest,
                                      input logic [BYTE_W-1:0] src,
                                      input logic [LEN_W-1:0] len_field,
                                      input int unsigned n_body,
                                      input int unsigned fill,
                                      input bit cks_ok);
      logic [BYTE_W-1:0] body[MAX_PAYLOAD];
      logic [CKS_W-1:0]  sum;
      logic [CKS_W-1:0]  cks;
      int unsigned       i;
      sum = '0;
      for (i = 0; i < n_body; i++) begin
         body[i] = (fill == 1) ? 8'hFF : (fill == 2) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
         sum = sum + CKS_W'(body[i]);
      end
      cks = cks_ok ? sum : sum ^ CKS_W'($urandom_range(1, 65535));
      for (i = 0; i < START_BYTES; i++)
         rx_bytes_pending.push_back(cfg_start_word[WORD_W-1-8*i -: 8]);
      rx_bytes_pending.push_back(msg[7:0]);
      rx_bytes_pending.push_back(msg[15:8]);
      rx_bytes_pending.push_back(dest);
      rx_bytes_pending.push_back(src);
      rx_bytes_pending.push_back(len_field[7:0]);
      rx_bytes_pending.push_back(len_field[15:8]);
      rx_bytes_pending.push_back(cks[7:0]);
      rx_bytes_pending.push_back(cks[15:8]);
      for (i = 0; i < n_body; i++) rx_bytes_pending.push_back(body[i]);
   endfunction

   // well-formed frame for this device with random content
   function automatic void push_good_frame(input int unsigned len);
      push_frame(MSG_NUM_W'($urandom_range(0, 65535)), cfg_device_id,
                 cfg_device_id ^ BYTE_W'($urandom_range(1, 255)), LEN_W'(len), len, 0, 1'b1);
   endfunction

   // first k start bytes, then a byte that breaks the start word at position k
   function automatic void push_broken_start(input int unsigned k);
      logic [BYTE_W-1:0] first;
      logic [BYTE_W-1:0] want;
      int unsigned       i;
      first = cfg_start_word[WORD_W-1 -: 8];
      want  = cfg_start_word[WORD_W-1-8*k -: 8];
      for (i = 0; i < k; i++)
         rx_bytes_pending.push_back(cfg_start_word[WORD_W-1-8*i -: 8]);
      // prefer the first start byte as the breaking byte, it must not restart the match
      rx_bytes_pending.push_back((k > 0 && first != want) ? first : ~want);
   endfunction

   function automatic int unsigned random_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 8);
      return $urandom_range(9, MAX_PAYLOAD);
   endfunction

   task automatic run_random_phase(input int unsigned n_bytes);
      int unsigned r;
      int unsigned len;
      int unsigned i;
      while (rx_bytes_pending.size() < n_bytes) begin
         r = $urandom_range(0, 99);
         if (r < 68) begin
            push_good_frame(random_length());
         end else if (r < 76) begin
            len = random_length();
            push_frame(MSG_NUM_W'($urandom), cfg_device_id, ~cfg_device_id, LEN_W'(len),
                       len, 0, len == 0 ? ($urandom_range(0, 3) == 0) : 1'b0);
         end else if (r < 80) begin
            len = random_length();
            push_frame(MSG_NUM_W'($urandom), cfg_device_id ^ BYTE_W'($urandom_range(1, 255)),
                       BYTE_W'($urandom), LEN_W'(len), len, 0, 1'b1);
         end else if (r < 83) begin
            len = random_length();
            push_frame(MSG_NUM_W'($urandom), cfg_device_id, cfg_device_id, LEN_W'(len),
                       len, 0, 1'b1);
         end else if (r < 87) begin
            // length that cannot fit; the count runs out at the frame size
            push_frame(MSG_NUM_W'($urandom), cfg_device_id, ~cfg_device_id,
                       LEN_W'($urandom_range(MAX_PAYLOAD + 1, 65535)), MAX_PAYLOAD, 0, 1'b1);
         end else if (r < 91) begin
            // truncated frame, later bytes fall into its payload
            len = $urandom_range(1, 8);
            push_frame(MSG_NUM_W'($urandom), cfg_device_id, ~cfg_device_id, LEN_W'(len + 4),
                       len, 0, 1'b1);
         end else if (r < 96) begin
            push_broken_start($urandom_range(0, START_BYTES - 1));
         end else begin
            for (i = 0; i < $urandom_range(1, 5); i++)
               rx_bytes_pending.push_back(BYTE_W'($urandom));
         end
      end
   endtask

   // sender pause: everything offered, every word back, then let the block settle
   task automatic drain_and_settle();
      while (rx_bytes_pending.size() != 0 || req_valid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned p;
      cfg_start_word = '0;
      cfg_device_id  = '0;
      rx_pos         = 0;
      hdr_msg_num    = '0;
      hdr_src        = '0;
      hdr_len        = '0;
      hdr_cks        = '0;
      payload_sum    = '0;
      foreach (frame_mem[i]) frame_mem[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed cases, distinct start bytes so the hunt cases are visible
      write_csr(CSR_START_WORD, 32'h8E1B_6C3D);
      write_csr(CSR_DEVICE_ID, 32'h0000_005A);
      push_frame(16'hFFFF, 8'h5A, 8'h00, 16'd1, 1, 1, 1'b1);   // one all-ones byte
      push_frame(16'h0000, 8'h5A, 8'hFF, 16'd0, 0, 0, 1'b1);   // empty frame, zero checksum
      push_frame(16'h1234, 8'h5A, 8'h01, 16'd0, 0, 0, 1'b0);   // empty frame, bad checksum
      push_frame(16'h0F0F, 8'hA5, 8'h01, 16'd2, 2, 0, 1'b1);   // not addressed to us
      push_frame(16'hF0F0, 8'h5A, 8'h5A, 16'd2, 2, 0, 1'b1);   // sent by ourselves
      push_frame(16'h5555, 8'h5A, 8'h33, 16'd3, 3, 0, 1'b0);   // checksum mismatch
      rx_bytes_pending.push_back(8'h00);                       // mismatch at the first byte
      push_broken_start(1);
      push_broken_start(2);
      push_broken_start(3);
      push_frame(16'hAAAA, 8'h5A, 8'h77, 16'hFFFF, MAX_PAYLOAD, 1, 1'b1);   // oversized
      push_frame(16'h0001, 8'h5A, 8'h66, LEN_W'(MAX_PAYLOAD + 1), MAX_PAYLOAD, 0, 1'b1);
      push_frame(16'h8000, 8'h5A, 8'h80, LEN_W'(MAX_PAYLOAD), MAX_PAYLOAD, 2, 1'b1);
      push_frame(16'h7FFF, 8'h5A, 8'h7F, LEN_W'(MAX_PAYLOAD), MAX_PAYLOAD, 0, 1'b1);
      push_frame(16'h00FF, 8'h5A, 8'hFE, 16'd2, 2, 2, 1'b1);
      drain_and_settle();

      // extremes: all-ones start word and address, gaps on both sides
      write_csr(CSR_START_WORD, 32'hFFFF_FFFF);
      write_csr(CSR_DEVICE_ID, 32'h0000_00FF);
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      run_random_phase(20);
      drain_and_settle();

      // all-zero start word and address, no idling at all
      write_csr(CSR_START_WORD, 32'h0000_0000);
      write_csr(CSR_DEVICE_ID, 32'h0000_0000);
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      run_random_phase(20);
      drain_and_settle();

      // receiver holds off while the sender keeps offering; the block must stall its input
      write_csr(CSR_START_WORD, WORD_W'($urandom));
      write_csr(CSR_DEVICE_ID, WORD_W'($urandom_range(0, 255)));
      hold_request = 1'b1;
      for (p = 0; p < 3; p++) push_good_frame($urandom_range(10, 20));
      drain_and_settle();

      // random settings, random idling
      for (p = 0; p < 2; p++) begin
         write_csr(CSR_START_WORD, WORD_W'($urandom));
         write_csr(CSR_DEVICE_ID, WORD_W'($urandom_range(0, 255)));
         send_gaps = 1'b1;
         recv_gaps = 1'b1;
         run_random_phase(20);
         drain_and_settle();
      end

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit, well past the slowest legal run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
src/afr_pkg.sv
src/addressed_frame_receiver_unit.sv
src/afr_checker.sv
test/addressed_frame_receiver_unit_tb.sv
